/* hw/rtl/chd_pkg.sv */
`default_nettype none
package chd_pkg;

  // Fixed field widths of the request and result.
  localparam int OP_W     = 2;
  localparam int SYM_W    = 9;
  localparam int LEN_W    = 4;
  localparam int WIN_W    = 15;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 1;

  // Number of stream bits a decode looks at, most significant bit first.
  localparam int MAX_CODE_BITS = 15;

  // Number of code lengths tracked by the per-length counters.
  localparam int NUM_LENGTHS = 16;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_CLEAR  = 2'd0;
  localparam logic [OP_W-1:0] OP_LOAD   = 2'd1;
  localparam logic [OP_W-1:0] OP_DECODE = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_LEN_LIMIT    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SYMBOL_COUNT = 1'd1;

  // Configuration reset values.
  localparam logic [LEN_W-1:0] LEN_LIMIT_RESET    = 4'd15;
  localparam logic [CFG_W-1:0] SYMBOL_COUNT_RESET = 10'd512;

  typedef struct packed {
    logic [OP_W-1:0]  op;
    logic [SYM_W-1:0] symbol_index;
    logic [LEN_W-1:0] code_length;
    logic [WIN_W-1:0] bit_window;
  } req_t;

  typedef struct packed {
    logic [SYM_W-1:0] decoded_symbol;
    logic [LEN_W-1:0] bits_used;
    logic             error;
  } res_t;

  typedef struct packed {
    logic [LEN_W-1:0] len_limit;
    logic [CFG_W-1:0] symbol_count;
  } cfg_t;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_LOAD_DEC,
    S_LOAD_INC,
    S_DEC_LEN,
    S_SCAN
  } state_t;

endpackage
`default_nettype wire

/* hw/rtl/chd_len_mem.sv */
`default_nettype none
module chd_len_mem #(
  parameter int DEPTH = 512,
  parameter int AW    = 9
) (
  input  wire                          clk,
  input  wire                          we,
  input  wire [AW-1:0]                 waddr,
  input  wire [chd_pkg::LEN_W-1:0]     wdata,
  input  wire [AW-1:0]                 raddr,
  output logic [chd_pkg::LEN_W-1:0]    rdata
);
  import chd_pkg::*;

  logic [LEN_W-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

/* hw/rtl/chd_seq.sv */
`default_nettype none
module chd_seq #(
  parameter int MAX_SYMBOLS = 512,
  parameter int AW = 9,
  parameter int SW = 10,
  parameter int CW = 10
) (
  input  wire                        clk,
  input  wire                        rst,
  input  wire                        start,
  input  wire chd_pkg::req_t         request,
  input  wire chd_pkg::cfg_t         cfg,
  output logic                       busy,
  output logic                       done,
  output chd_pkg::res_t              result,
  output logic                       mem_we,
  output logic [AW-1:0]              mem_waddr,
  output logic [chd_pkg::LEN_W-1:0]  mem_wdata,
  output logic [AW-1:0]              mem_raddr,
  input  wire  [chd_pkg::LEN_W-1:0]  mem_rdata
);
  import chd_pkg::*;

  localparam int FW = CW + MAX_CODE_BITS + 1;

  state_t state, state_next;

  logic [SW-1:0]    ptr;
  logic [AW-1:0]    idx;
  logic [LEN_W-1:0] newlen;
  logic [WIN_W-1:0] window;
  logic [LEN_W-1:0] limit;
  logic [LEN_W-1:0] len;
  logic [WIN_W-1:0] code;
  logic [FW-1:0]    first;
  logic [CW-1:0]    rank;
  logic             rd_vld;
  logic [SW-1:0]    rd_sym;
  logic             clr_report;
  logic [CW-1:0]    counts [NUM_LENGTHS];

  logic             accept;
  logic             load_ok;
  logic [LEN_W-1:0] cnt_addr;
  logic [CW-1:0]    cnt_rd;
  logic [3:0]       bit_pos;
  logic [WIN_W-1:0] code_cur;
  logic [FW:0]      diff;
  logic             hit;
  logic [FW-1:0]    first_adv;
  logic             sweep_last;
  logic             scan_issue;

  assign accept     = start && (state == S_IDLE);
  assign load_ok    = ({1'b0, request.symbol_index} < cfg.symbol_count) &&
                      (int'(request.symbol_index) < MAX_SYMBOLS);
  assign sweep_last = (ptr == SW'(MAX_SYMBOLS - 1));
  assign scan_issue = (ptr < SW'(MAX_SYMBOLS));
  assign busy       = (state != S_IDLE);

  // Single read port on the per-length counters.
  always_comb begin
    case (state)
      S_LOAD_DEC: cnt_addr = mem_rdata;
      S_LOAD_INC: cnt_addr = newlen;
      default:    cnt_addr = len;
    endcase
  end
  assign cnt_rd = counts[cnt_addr];

  // Shared compare unit: is the running code inside this length's range?
  assign bit_pos   = 4'(MAX_CODE_BITS - int'(len));
  assign code_cur  = code | WIN_W'(window[bit_pos]);
  assign diff      = {1'b0, FW'(code_cur)} - {1'b0, first};
  assign hit       = !diff[FW] && (diff[FW-1:0] < FW'(cnt_rd));
  assign first_adv = FW'((first + FW'(cnt_rd)) << 1);

  // Next state and memory control.
  always_comb begin
    state_next = state;
    mem_we     = 1'b0;
    mem_waddr  = idx;
    mem_wdata  = newlen;
    mem_raddr  = ptr[AW-1:0];
    case (state)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = ptr[AW-1:0];
        mem_wdata = '0;
        if (sweep_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        mem_raddr = AW'(request.symbol_index);
        if (accept) begin
          case (request.op)
            OP_CLEAR:  state_next = S_CLEAR;
            OP_LOAD:   state_next = load_ok ? S_LOAD_DEC : S_IDLE;
            OP_DECODE: state_next = (cfg.len_limit == '0) ? S_IDLE : S_DEC_LEN;
            default:   state_next = S_IDLE;
          endcase
        end
      end
      S_LOAD_DEC: begin
        mem_we     = 1'b1;
        state_next = S_LOAD_INC;
      end
      S_LOAD_INC: state_next = S_IDLE;
      S_DEC_LEN: begin
        if (hit) begin
          state_next = S_SCAN;
        end else if (len == limit) begin
          state_next = S_IDLE;
        end
      end
      S_SCAN: begin
        if (rd_vld && (mem_rdata == len) && (rank == '0)) begin
          state_next = S_IDLE;
        end else if (!rd_vld && !scan_issue) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Control counters, per-length counts and the result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      ptr        <= '0;
      clr_report <= 1'b0;
      done       <= 1'b0;
      rd_vld     <= 1'b0;
      for (int i = 0; i < NUM_LENGTHS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      done <= 1'b0;
      case (state)
        S_CLEAR: begin
          ptr <= ptr + SW'(1);
          if (sweep_last) begin
            done <= clr_report;
          end
        end
        S_IDLE: begin
          if (accept) begin
            case (request.op)
              OP_CLEAR: begin
                ptr        <= '0;
                clr_report <= 1'b1;
                for (int i = 0; i < NUM_LENGTHS; i++) begin
                  counts[i] <= '0;
                end
              end
              OP_LOAD:   done <= !load_ok;
              OP_DECODE: done <= (cfg.len_limit == '0);
              default:   done <= 1'b1;
            endcase
          end
        end
        S_LOAD_DEC: begin
          if ((mem_rdata != '0) && (cnt_rd != '0)) begin
            counts[mem_rdata] <= cnt_rd - CW'(1);
          end
        end
        S_LOAD_INC: begin
          if (newlen != '0) begin
            counts[newlen] <= cnt_rd + CW'(1);
          end
          done <= 1'b1;
        end
        S_DEC_LEN: begin
          if (hit) begin
            ptr    <= '0;
            rd_vld <= 1'b0;
          end else if (len == limit) begin
            done <= 1'b1;
          end
        end
        S_SCAN: begin
          rd_vld <= scan_issue;
          if (scan_issue) begin
            ptr <= ptr + SW'(1);
          end
          if (state_next == S_IDLE) begin
            done <= 1'b1;
          end
        end
        default: done <= 1'b0;
      endcase
    end
  end

  // Datapath registers of the current request.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        idx    <= AW'(request.symbol_index);
        newlen <= request.code_length;
        window <= request.bit_window;
        limit  <= cfg.len_limit;
        len    <= LEN_W'(1);
        code   <= '0;
        first  <= '0;
        result <= '0;
        if (accept && (request.op == OP_LOAD) && !load_ok) begin
          result.error <= 1'b1;
        end
        if (accept && (request.op == OP_DECODE) && (cfg.len_limit == '0)) begin
          result.error <= 1'b1;
        end
      end
      S_CLEAR, S_LOAD_DEC, S_LOAD_INC: result <= '0;
      S_DEC_LEN: begin
        if (hit) begin
          rank <= diff[CW-1:0];
        end else if (len == limit) begin
          result       <= '0;
          result.error <= 1'b1;
        end else begin
          first <= first_adv;
          code  <= WIN_W'(code_cur << 1);
          len   <= len + LEN_W'(1);
        end
      end
      S_SCAN: begin
        rd_sym <= ptr;
        if (rd_vld && (mem_rdata == len)) begin
          if (rank == '0) begin
            result.decoded_symbol <= SYM_W'(rd_sym);
            result.bits_used      <= len;
            result.error          <= 1'b0;
          end else begin
            rank <= rank - CW'(1);
          end
        end else if (!rd_vld && !scan_issue) begin
          result       <= '0;
          result.error <= 1'b1;
        end
      end
      default: result <= '0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/canonical_huffman_decoder_top.sv */
`default_nettype none
// Canonical Huffman decoder: one request at a time, busy while it works.
// An unknown op, a rejected load or a zero length limit is answered from idle; a load
// passes through S_LOAD_DEC and S_LOAD_INC; a clear sweeps the length memory; a decode
// walks the lengths to a match or the length limit, then scans the length memory serially
// through its single registered read port. The next request is taken while a result is strobed.
// Reset is synchronous; a clearing pass over the length memory then holds busy.
// Results are strobed on done for one cycle; the receiver cannot stall.
module canonical_huffman_decoder_top #(
  parameter int MAX_SYMBOLS = 512
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             start,
  output logic                            busy,
  input  wire chd_pkg::req_t              request,
  output logic                            done,
  output chd_pkg::res_t                   result,
  input  wire                             cfg_we,
  input  wire  [chd_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  wire  [chd_pkg::CFG_W-1:0]       cfg_data
);
  import chd_pkg::*;

  localparam int AW = $clog2(MAX_SYMBOLS);
  localparam int SW = $clog2(MAX_SYMBOLS + 1);
  localparam int CW = $clog2(MAX_SYMBOLS + 1);

  cfg_t             cfg;
  logic             mem_we;
  logic [AW-1:0]    mem_waddr;
  logic [LEN_W-1:0] mem_wdata;
  logic [AW-1:0]    mem_raddr;
  logic [LEN_W-1:0] mem_rdata;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.len_limit    <= LEN_LIMIT_RESET;
      cfg.symbol_count <= SYMBOL_COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_LEN_LIMIT:    cfg.len_limit    <= cfg_data[LEN_W-1:0];
        CFG_SYMBOL_COUNT: cfg.symbol_count <= cfg_data;
        default:          cfg <= cfg;
      endcase
    end
  end

  chd_seq #(
    .MAX_SYMBOLS (MAX_SYMBOLS),
    .AW          (AW),
    .SW          (SW),
    .CW          (CW)
  ) u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .request   (request),
    .cfg       (cfg),
    .busy      (busy),
    .done      (done),
    .result    (result),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata)
  );

  chd_len_mem #(
    .DEPTH (MAX_SYMBOLS),
    .AW    (AW)
  ) u_len_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

endmodule
`default_nettype wire

/* test/testbench.sv */
`default_nettype none
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import chd_pkg::*;

  localparam int ALPHABET_SIZE = 512;
  localparam int LIMIT_CYCLES  = 5_000_000;
  localparam int SETTLE_CYCLES = 600;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  logic               clk       = 1'b0;
  logic               rst       = 1'b1;
  logic               start     = 1'b0;
  logic               busy;
  req_t               request   = '0;
  logic               done;
  res_t               result;
  logic               cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0]   cfg_data  = '0;

  canonical_huffman_decoder_top #(
    .MAX_SYMBOLS(ALPHABET_SIZE)
  ) uut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .request(request),
    .done(done),
    .result(result),
    .cfg_we(cfg_we),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  // Free-running 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Shadow copy of the code length table and the per-length populations.
  logic [LEN_W-1:0] model_lengths [ALPHABET_SIZE];
  int unsigned      model_counts  [NUM_LENGTHS];
  logic [LEN_W-1:0] cur_len_limit;
  logic [CFG_W-1:0] cur_symbol_count;

  res_t expected_results [$];
  res_t oldest;
  int   idle_pct        = 0;
  int   items_sent      = 0;
  int   results_checked = 0;
  int   mismatches      = 0;
  int   cycle_count     = 0;
  int   clears          = 0;
  int   loads           = 0;
  int   decodes         = 0;
  int   errors_expected = 0;

  function automatic void clear_tables();
    foreach (model_lengths[s]) model_lengths[s] = '0;
    foreach (model_counts[l]) model_counts[l] = 0;
  endfunction

  // Canonical first-code search: walk the window one bit per length and
  // find the rank of the code among symbols of that length.
  function automatic res_t decode_window(input logic [WIN_W-1:0] window);
    res_t        r;
    int unsigned code;
    int unsigned first_code;
    int unsigned rank;
    int unsigned limit;
    int          len;
    int          s;
    r = '0;
    r.error = 1'b1;
    limit = cur_len_limit;
    if (limit > MAX_CODE_BITS) limit = MAX_CODE_BITS;
    code = 0;
    first_code = 0;
    for (len = 1; len <= limit; len++) begin
      code = code | int'(window[WIN_W - len]);
      if (code >= first_code && code - first_code < model_counts[len]) begin
        rank = code - first_code;
        for (s = 0; s < ALPHABET_SIZE; s++) begin
          if (model_lengths[s] == len) begin
            if (rank == 0) begin
              r.decoded_symbol = SYM_W'(s);
              r.bits_used = LEN_W'(len);
              r.error = 1'b0;
              return r;
            end
            rank--;
          end
        end
        return r;
      end
      first_code = (first_code + model_counts[len]) << 1;
      code = code << 1;
    end
    return r;
  endfunction

  // Applies one accepted request to the shadow tables and returns its result.
  function automatic res_t apply_request(input req_t r);
    res_t             out;
    logic [LEN_W-1:0] old_len;
    out = '0;
    case (r.op)
      OP_CLEAR: begin
        clear_tables();
        clears++;
      end
      OP_LOAD: begin
        loads++;
        if (CFG_W'(r.symbol_index) >= cur_symbol_count) begin
          out.error = 1'b1;
        end else begin
          old_len = model_lengths[r.symbol_index];
          if (old_len != 0 && model_counts[old_len] > 0) model_counts[old_len]--;
          model_lengths[r.symbol_index] = r.code_length;
          if (r.code_length != 0) model_counts[r.code_length]++;
        end
      end
      OP_DECODE: begin
        decodes++;
        out = decode_window(r.bit_window);
      end
      default: ;
    endcase
    if (out.error) errors_expected++;
    return out;
  endfunction

  function automatic req_t make_request(input logic [OP_W-1:0] op,
                                        input logic [SYM_W-1:0] idx,
                                        input logic [LEN_W-1:0] len,
                                        input logic [WIN_W-1:0] window);
    req_t r;
    r.op = op;
    r.symbol_index = idx;
    r.code_length = len;
    r.bit_window = window;
    return r;
  endfunction

  function automatic req_t random_request();
    req_t r;
    r.op = OP_W'($urandom);
    r.symbol_index = SYM_W'($urandom);
    r.code_length = LEN_W'($urandom);
    r.bit_window = WIN_W'($urandom);
    return r;
  endfunction

  // Windows with long runs of leading ones or zeros reach the deep codes.
  function automatic logic [WIN_W-1:0] rand_window();
    logic [WIN_W-1:0] w;
    int               style;
    w = WIN_W'($urandom);
    style = $urandom_range(2);
    if (style == 0) w = w | ({WIN_W{1'b1}} << $urandom_range(WIN_W));
    else if (style == 1) w = w >> $urandom_range(WIN_W);
    return w;
  endfunction

  // Presents one request, waits until it is taken, and records its result.
  task automatic send_request(input req_t r);
    start <= 1'b1;
    request <= r;
    do @(posedge clk); while (busy);
    expected_results.push_back(apply_request(r));
    items_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat (($urandom_range(19) == 0) ? $urandom_range(100, 700) : $urandom_range(1, 30))
        @(posedge clk);
    end
  endtask

  // Holds requests off until every pending result has come back.
  task automatic wait_idle();
    start <= 1'b0;
    do @(posedge clk); while (expected_results.size() != 0 || busy);
  endtask

  task automatic set_config(input logic [LEN_W-1:0] max_len,
                            input logic [CFG_W-1:0] sym_count);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_index <= CFG_LEN_LIMIT;
    cfg_data <= CFG_W'(max_len);
    @(posedge clk);
    cur_len_limit = max_len;
    cfg_index <= CFG_SYMBOL_COUNT;
    cfg_data <= sym_count;
    @(posedge clk);
    cur_symbol_count = sym_count;
    cfg_we <= 1'b0;
  endtask

  // Clears the table, loads a prefix code built by splitting leaves, then
  // decodes random windows. Some sets are left incomplete or over-subscribed,
  // and stray requests are mixed in between the loads.
  task automatic send_code_set(input int depth_cap, input int decode_count);
    int unsigned      code_lens [$];
    bit               taken [ALPHABET_SIZE];
    int               target;
    int               pick;
    int               tries;
    int               idx;
    int               broken;
    logic [LEN_W-1:0] grown;
    send_request(make_request(OP_CLEAR, SYM_W'($urandom), LEN_W'($urandom),
                              WIN_W'($urandom)));
    target = $urandom_range(2, 12);
    if (target > cur_symbol_count) target = cur_symbol_count;
    if (target < 2) code_lens.push_back($urandom_range(1, depth_cap));
    else code_lens = {1, 1};
    tries = 0;
    while (code_lens.size() < target && tries < 64) begin
      pick = ($urandom_range(3) == 0) ? code_lens.size() - 1
                                      : $urandom_range(code_lens.size() - 1);
      if (code_lens[pick] < depth_cap) begin
        grown = LEN_W'(code_lens[pick] + 1);
        code_lens.delete(pick);
        code_lens.push_back(grown);
        code_lens.push_back(grown);
      end
      tries++;
    end
    broken = $urandom_range(9);
    if (broken == 0 && code_lens.size() > 1) begin
      void'(code_lens.pop_front());
    end else if (broken == 1 && code_lens.size() < cur_symbol_count) begin
      code_lens.push_back($urandom_range(1, depth_cap));
    end
    foreach (code_lens[i]) begin
      do idx = $urandom_range(cur_symbol_count - 1); while (taken[idx]);
      taken[idx] = 1'b1;
      if ($urandom_range(9) == 0) send_request(random_request());
      send_request(make_request(OP_LOAD, SYM_W'(idx), LEN_W'(code_lens[i]),
                                WIN_W'($urandom)));
    end
    repeat (decode_count) begin
      send_request(make_request(OP_DECODE, SYM_W'($urandom), LEN_W'($urandom),
                                rand_window()));
    end
  endtask

  task automatic run_phase(input logic [LEN_W-1:0] max_len,
                           input logic [CFG_W-1:0] sym_count,
                           input int idle, input int count);
    int stop_at;
    set_config(max_len, sym_count);
    idle_pct = idle;
    stop_at = items_sent + count;
    while (items_sent < stop_at) begin
      send_code_set(($urandom_range(3) == 0) ? MAX_CODE_BITS : int'(cur_len_limit),
                    $urandom_range(4, 24));
      if ($urandom_range(9) == 0) wait_idle();
    end
  endtask

  // Hand-picked table: one code of each length 1 and 2, two of length 3.
  task automatic test_directed();
    idle_pct = 0;
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd1, 4'd1, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd0, 4'd2, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd2, 4'd3, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd511, 4'd15, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd511, 4'd3, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd5, 4'd0, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd511, 4'd15, 15'h7FFF));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h4000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h6000));
    send_request(make_request(OP_UNUSED, 9'd511, 4'd15, 15'h7FFF));
    // A small alphabet rejects loads outside it but keeps the symbol at 511.
    set_config(4'd15, 10'd4);
    send_request(make_request(OP_LOAD, 9'd4, 4'd2, 15'h0000));
    send_request(make_request(OP_LOAD, 9'd3, 4'd5, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h7FFF));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h7C00));
    // Codes longer than the length limit must fail.
    set_config(4'd2, 10'd4);
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h6000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h4000));
    // A lone 15-bit code leaves every other window a dead end.
    set_config(4'd15, 10'd512);
    send_request(make_request(OP_CLEAR, 9'd0, 4'd0, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h7FFF));
    send_request(make_request(OP_LOAD, 9'd511, 4'd15, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h0000));
    send_request(make_request(OP_DECODE, 9'd0, 4'd0, 15'h0001));
  endtask

  task automatic test_back_to_back();
    run_phase(4'd15, 10'd512, 0, 280);
  endtask

  task automatic test_tiny_alphabet();
    run_phase(4'd1, 10'd1, 0, 90);
  endtask

  task automatic test_sparse_requests();
    run_phase(4'd9, 10'd37, 72, 280);
  endtask

  task automatic test_mixed_idle();
    run_phase(4'd12, 10'd300, 17, 280);
  endtask

  task automatic test_random_settings();
    int pick;
    repeat (4) begin
      pick = $urandom_range(2);
      run_phase(LEN_W'($urandom_range(1, 15)), CFG_W'($urandom_range(1, 512)),
                (pick == 0) ? 0 : (pick == 1) ? 17 : 72, 20);
    end
  endtask

  // Each strobed result is compared with the oldest pending expectation.
  always @(posedge clk) begin
    if (!rst && done) begin
      if (expected_results.size() == 0) begin
        $display("%0t ns: unexpected result, expected none, got %p", $time, result);
        mismatches++;
      end else begin
        oldest = expected_results.pop_front();
        results_checked++;
        if (result.decoded_symbol !== oldest.decoded_symbol) begin
          $display("%0t ns: decoded_symbol expected %0d, got %0d", $time,
                   oldest.decoded_symbol, result.decoded_symbol);
          mismatches++;
        end
        if (result.bits_used !== oldest.bits_used) begin
          $display("%0t ns: bits_used expected %0d, got %0d", $time,
                   oldest.bits_used, result.bits_used);
          mismatches++;
        end
        if (result.error !== oldest.error) begin
          $display("%0t ns: error expected %0b, got %0b", $time,
                   oldest.error, result.error);
          mismatches++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == LIMIT_CYCLES) begin
      $display("Run stopped after %0d cycles with %0d results outstanding.",
               cycle_count, expected_results.size());
      $display("testbench failed");
      $finish;
    end
  end

  initial begin
    clear_tables();
    cur_len_limit = LEN_LIMIT_RESET;
    cur_symbol_count = SYMBOL_COUNT_RESET;
    repeat (8) @(posedge clk);
    rst <= 1'b0;

    test_directed();
    test_back_to_back();
    test_tiny_alphabet();
    test_sparse_requests();
    test_mixed_idle();
    test_random_settings();

    wait_idle();
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d requests (%0d clears, %0d loads, %0d decodes); checked %0d results,",
             items_sent, clears, loads, decodes, results_checked);
    $display("%0d flagged as errors, over length limits 1 to 15 and alphabets of 1 to 512.",
             errors_expected);
    if (mismatches == 0 && expected_results.size() == 0) begin
      $display("testbench passed");
    end else begin
      $display("testbench failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

/* filelist.f */
hw/rtl/chd_pkg.sv
hw/rtl/chd_len_mem.sv
hw/rtl/chd_seq.sv
hw/rtl/canonical_huffman_decoder_top.sv
test/testbench.sv
